[hw/rtl/whitespace_word_tokenizer_core_defines.svh]
// Assertion macros for the whitespace word tokenizer.
// Included by the tokenizer core, which checks its own logic; no other dependencies.
`ifndef WHITESPACE_WORD_TOKENIZER_CORE_DEFINES_SVH
`define WHITESPACE_WORD_TOKENIZER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define WWT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("wwt: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define WWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("wwt: next-cycle check failed");
`else
`define WWT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WWT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/wwt_pkg.sv]
// Package for the whitespace word tokenizer: widths, character codes,
// token kinds and the result record. No dependencies.
package wwt_pkg;

	localparam int OFFSET_WIDTH = 24;
	localparam int LINE_WIDTH   = 20;
	localparam int COLUMN_WIDTH = 16;
	localparam int LIMIT_WIDTH  = 4;
	localparam int LEN_WIDTH    = 4;

	localparam int RES_BITS  = 2 * OFFSET_WIDTH + LINE_WIDTH + 2 * COLUMN_WIDTH;
	localparam int TDATA_W   = ((RES_BITS + 7) / 8) * 8;
	localparam int TDATA_PAD = TDATA_W - RES_BITS;
	localparam int TUSER_W   = 8;

	localparam logic [LIMIT_WIDTH-1:0] WORD_LIMIT_RESET = LIMIT_WIDTH'(12);

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [2:0] {
		KIND_PERIOD = 3'd0,
		KIND_COMMA  = 3'd1,
		KIND_SEMI   = 3'd2,
		KIND_GROUP  = 3'd3,
		KIND_NUMBER = 3'd4,
		KIND_WORD   = 3'd5,
		KIND_EOF    = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t                    token_kind;
		logic [OFFSET_WIDTH-1:0]  start_offset;
		logic [OFFSET_WIDTH-1:0]  end_offset;
		logic [LINE_WIDTH-1:0]    line_number;
		logic [COLUMN_WIDTH-1:0]  start_column;
		logic [COLUMN_WIDTH-1:0]  end_column;
		logic                     too_long;
		logic                     error_seen;
		logic                     last_result;
	} result_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) ||
			(b == CH_VT) || (b == CH_FF);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

[hw/rtl/whitespace_word_tokenizer_core.sv]
// Top level of the whitespace word tokenizer: scanner state, token
// classification and a three-entry result queue. Depends on wwt_pkg and the defines header.
`include "whitespace_word_tokenizer_core_defines.svh"

// Usage
// -----
// Source text enters on the s_ channel, one byte per request: s_tdata holds the
// byte and s_tlast marks the end of the source (the byte is then ignored).
// Tokens leave on the m_ channel. m_tdata carries offsets, line and columns,
// m_tuser the token kind and the too-long and error flags, m_tlast the
// end-of-file token. cfg_we writes the word limit from cfg_wdata; write it
// only while no request is in flight.
// A token enters the result queue when the request that ends it (the delimiter or
// end-of-source byte) is accepted. Throughput is one byte per clock while s_tready
// is high: the scanner state is updated in the accepting cycle by short logic, and
// results land in a three-entry queue. s_tready is high while the queue holds
// one result or fewer, so an end of source that closes an open token (two results)
// can hold s_tready low until the receiver takes a result, even when it keeps up.
// If the receiver stalls, the queue fills and s_tready drops once it holds two or
// more results; nothing is lost. Reset empties the queue, clears the scanner
// to offset 0, line 1, column 1 and sets the word limit to 12. An end-of-source
// request returns the scanner to that state but keeps the word limit.
module whitespace_word_tokenizer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration: word limit.
	input  logic                         cfg_we,
	input  logic [wwt_pkg::LIMIT_WIDTH-1:0] cfg_wdata,
	// Source bytes.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] source_byte
	input  logic                         s_tlast,   // end_of_source
	// Tokens.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [23:0] start_offset, [47:24] end_offset, [67:48] line_number,
	// [83:68] start_column, [99:84] end_column, [103:100] zero
	output logic [wwt_pkg::TDATA_W-1:0]  m_tdata,
	// [2:0] token_kind, [3] too_long, [4] error_seen, [7:5] zero
	output logic [wwt_pkg::TUSER_W-1:0]  m_tuser,
	output logic                         m_tlast    // last_result
);
	import wwt_pkg::*;

	localparam int QDEPTH = 3;

	// Scanner state.
	logic [LIMIT_WIDTH-1:0]  word_limit_q;
	logic                    in_token_q, in_comment_q, pending_cr_q;
	logic                    length_over_q, digits_only_q, sticky_error_q;
	logic [OFFSET_WIDTH-1:0] byte_offset_q, token_start_q;
	logic [LINE_WIDTH-1:0]   cur_line_q;
	logic [COLUMN_WIDTH-1:0] cur_column_q, token_column_q;
	logic [LEN_WIDTH-1:0]    token_length_q;
	logic [7:0]              first_byte_q, prev_byte_q;

	logic                    in_token_n, in_comment_n, pending_cr_n;
	logic                    length_over_n, digits_only_n, sticky_error_n;
	logic [OFFSET_WIDTH-1:0] byte_offset_n, token_start_n;
	logic [LINE_WIDTH-1:0]   cur_line_n;
	logic [COLUMN_WIDTH-1:0] cur_column_n, token_column_n;
	logic [LEN_WIDTH-1:0]    token_length_n;
	logic [7:0]              first_byte_n, prev_byte_n;

	// Result queue.
	result_t     queue_q [QDEPTH];
	logic [1:0]  wr_ptr_q, rd_ptr_q, count_q;
	logic [1:0]  push_cnt;
	logic        pop;
	result_t     res0, res1, tok_res, eof_res, head;

	logic        s_accept;
	logic        flush_tl;
	logic [7:0]  b;
	logic [OFFSET_WIDTH-1:0] off_inc;
	logic [LINE_WIDTH-1:0]   line_inc;
	logic [COLUMN_WIDTH-1:0] col_inc;

	function automatic logic [1:0] ptr_inc(input logic [1:0] p);
		return (p == 2'(QDEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	assign s_accept = s_tvalid && s_tready;
	assign s_tready = (count_q <= 2'd1);
	assign b        = s_tdata;

	// Saturating increments of the position counters.
	assign off_inc  = (&byte_offset_q) ? byte_offset_q : byte_offset_q + 1'b1;
	assign line_inc = (&cur_line_q) ? cur_line_q : cur_line_q + 1'b1;
	assign col_inc  = (&cur_column_q) ? cur_column_q : cur_column_q + 1'b1;

	// The token that closes now, if one is open, and the end-of-file record.
	assign flush_tl = length_over_q || (token_length_q > word_limit_q);

	always_comb begin
		tok_res              = '0;
		if ((token_length_q == LEN_WIDTH'(1)) && (first_byte_q == CH_PERIOD)) begin
			tok_res.token_kind = KIND_PERIOD;
		end else if ((token_length_q == LEN_WIDTH'(1)) && (first_byte_q == CH_COMMA)) begin
			tok_res.token_kind = KIND_COMMA;
		end else if ((token_length_q == LEN_WIDTH'(1)) && (first_byte_q == CH_SEMI)) begin
			tok_res.token_kind = KIND_SEMI;
		end else if ((token_length_q >= LEN_WIDTH'(3)) && (first_byte_q == CH_LPAREN) &&
			(prev_byte_q == CH_RPAREN)) begin
			tok_res.token_kind = KIND_GROUP;
		end else if (digits_only_q) begin
			tok_res.token_kind = KIND_NUMBER;
		end else begin
			tok_res.token_kind = KIND_WORD;
		end
		tok_res.start_offset = token_start_q;
		tok_res.end_offset   = byte_offset_q;
		tok_res.line_number  = cur_line_q;
		tok_res.start_column = token_column_q;
		tok_res.end_column   = cur_column_q;
		tok_res.too_long     = flush_tl;

		eof_res              = '0;
		eof_res.token_kind   = KIND_EOF;
		eof_res.start_offset = byte_offset_q;
		eof_res.end_offset   = byte_offset_q;
		eof_res.line_number  = cur_line_q;
		eof_res.start_column = cur_column_q;
		eof_res.end_column   = cur_column_q;
		eof_res.error_seen   = sticky_error_q || (in_token_q && flush_tl);
		eof_res.last_result  = 1'b1;
	end

	// Next-state logic for one accepted request.
	always_comb begin
		in_token_n     = in_token_q;
		in_comment_n   = in_comment_q;
		pending_cr_n   = pending_cr_q;
		length_over_n  = length_over_q;
		digits_only_n  = digits_only_q;
		sticky_error_n = sticky_error_q;
		byte_offset_n  = byte_offset_q;
		token_start_n  = token_start_q;
		cur_line_n     = cur_line_q;
		cur_column_n   = cur_column_q;
		token_column_n = token_column_q;
		token_length_n = token_length_q;
		first_byte_n   = first_byte_q;
		prev_byte_n    = prev_byte_q;
		res0           = tok_res;
		res1           = eof_res;
		push_cnt       = 2'd0;

		if (s_accept) begin
			if (s_tlast) begin
				// End of source: close an open token, then report end of file
				// and fall back to the reset state.
				if (in_token_q) begin
					push_cnt = 2'd2;
				end else begin
					res0     = eof_res;
					push_cnt = 2'd1;
				end
				in_token_n     = 1'b0;
				in_comment_n   = 1'b0;
				pending_cr_n   = 1'b0;
				length_over_n  = 1'b0;
				digits_only_n  = 1'b1;
				sticky_error_n = 1'b0;
				byte_offset_n  = '0;
				token_start_n  = '0;
				cur_line_n     = LINE_WIDTH'(1);
				cur_column_n   = COLUMN_WIDTH'(1);
				token_column_n = COLUMN_WIDTH'(1);
				token_length_n = '0;
				first_byte_n   = '0;
				prev_byte_n    = '0;
			end else begin
				pending_cr_n = 1'b0;
				if (pending_cr_q && (b == CH_LF)) begin
					// Second half of a CR LF pair: the line already advanced.
					byte_offset_n = off_inc;
				end else if (in_comment_q && (b != CH_CR) && (b != CH_LF)) begin
					byte_offset_n = off_inc;
				end else if (in_token_q && !is_space(b)) begin
					if (token_length_q != '1) begin
						token_length_n = token_length_q + 1'b1;
					end else begin
						length_over_n = 1'b1;
					end
					if (!is_digit(b)) begin
						digits_only_n = 1'b0;
					end
					prev_byte_n   = b;
					byte_offset_n = off_inc;
					cur_column_n  = col_inc;
				end else begin
					in_comment_n = 1'b0;
					if (in_token_q) begin
						push_cnt       = 2'd1;
						in_token_n     = 1'b0;
						sticky_error_n = sticky_error_q || flush_tl;
					end
					if (b == CH_CR) begin
						cur_line_n   = line_inc;
						cur_column_n = COLUMN_WIDTH'(1);
						pending_cr_n = 1'b1;
					end else if (b == CH_LF) begin
						cur_line_n   = line_inc;
						cur_column_n = COLUMN_WIDTH'(1);
					end else if (is_space(b)) begin
						cur_column_n = col_inc;
					end else if (b == CH_HASH) begin
						in_comment_n = 1'b1;
					end else begin
						in_token_n     = 1'b1;
						token_start_n  = byte_offset_q;
						token_column_n = cur_column_q;
						token_length_n = LEN_WIDTH'(1);
						length_over_n  = 1'b0;
						first_byte_n   = b;
						prev_byte_n    = b;
						digits_only_n  = is_digit(b);
						cur_column_n   = col_inc;
					end
					byte_offset_n = off_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_limit_q   <= WORD_LIMIT_RESET;
			in_token_q     <= 1'b0;
			in_comment_q   <= 1'b0;
			pending_cr_q   <= 1'b0;
			length_over_q  <= 1'b0;
			digits_only_q  <= 1'b1;
			sticky_error_q <= 1'b0;
			byte_offset_q  <= '0;
			token_start_q  <= '0;
			cur_line_q     <= LINE_WIDTH'(1);
			cur_column_q   <= COLUMN_WIDTH'(1);
			token_column_q <= COLUMN_WIDTH'(1);
			token_length_q <= '0;
			first_byte_q   <= '0;
			prev_byte_q    <= '0;
		end else begin
			if (cfg_we) begin
				word_limit_q <= cfg_wdata;
			end
			in_token_q     <= in_token_n;
			in_comment_q   <= in_comment_n;
			pending_cr_q   <= pending_cr_n;
			length_over_q  <= length_over_n;
			digits_only_q  <= digits_only_n;
			sticky_error_q <= sticky_error_n;
			byte_offset_q  <= byte_offset_n;
			token_start_q  <= token_start_n;
			cur_line_q     <= cur_line_n;
			cur_column_q   <= cur_column_n;
			token_column_q <= token_column_n;
			token_length_q <= token_length_n;
			first_byte_q   <= first_byte_n;
			prev_byte_q    <= prev_byte_n;
		end
	end

	// Result queue: up to two writes per cycle, one read.
	assign pop  = m_tvalid && m_tready;
	assign head = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (push_cnt == 2'd2) begin
			queue_q[ptr_inc(wr_ptr_q)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_cnt == 2'd1) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end else if (push_cnt == 2'd2) begin
				wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + push_cnt - {1'b0, pop};
		end
	end

	assign m_tvalid = (count_q != 2'd0);
	assign m_tdata  = {{TDATA_PAD{1'b0}}, head.end_column, head.start_column,
		head.line_number, head.end_offset, head.start_offset};
	assign m_tuser  = {3'b000, head.error_seen, head.too_long, head.token_kind};
	assign m_tlast  = head.last_result;

	// An accepted end of source always leaves a result to deliver.
	`WWT_ASSERT_NEXT(a_eof_queued, clk, arst_n, s_accept && s_tlast, m_tvalid)
	// End of source puts the scanner back at its starting position.
	`WWT_ASSERT_NEXT(a_eof_clears, clk, arst_n, s_accept && s_tlast,
		!in_token_q && !in_comment_q && (byte_offset_q == '0) && (cur_line_q == LINE_WIDTH'(1)))
	// A comment can only begin where no token is open.
	`WWT_ASSERT_IMP(a_comment_token, clk, arst_n, 1'b1, !(in_comment_q && in_token_q))
	// A pending CR never coexists with an open token.
	`WWT_ASSERT_IMP(a_cr_token, clk, arst_n, pending_cr_q, !in_token_q)

endmodule
